// File: design/sdl_pkg.sv
// ============================================================================
// sdl_pkg: shared types and codes of the sorted deque list
// Operation, status and position codes, and the control word that the
// sequencer broadcasts to every cell of the chain.
// ============================================================================
package sdl_pkg;

   localparam int MODE_BITS   = 3;
   localparam int STATUS_BITS = 2;
   localparam int KEY_BITS    = 32;
   localparam int FIELD_BITS  = 32;
   localparam int COUNT_BITS  = 5;

   localparam logic [MODE_BITS-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_INSERT     = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_POP_BACK   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE     = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

   // Where an insertion or a removal takes place.
   typedef enum logic [1:0] {
      POS_HEAD  = 2'd0,   // entry 0
      POS_END   = 2'd1,   // just past the tail (insert only)
      POS_LAST  = 2'd2,   // the tail entry
      POS_FIRST = 2'd3    // first flagged entry found by the scan
   } sdl_pos_type;

   typedef struct packed {
      logic        capture;    // request accepted: cells take their match flags
      logic        scan;       // chains move one cell this cycle
      logic        match_ge;   // flag entries >= key (insert) rather than == key
      logic        apply_ins;  // insert the new entry at pos
      logic        apply_del;  // remove the entry at pos
      sdl_pos_type pos;
   } sdl_ctrl_type;

endpackage

// File: design/sdl_cell.sv
// ============================================================================
// sdl_cell: one storage cell of the list chain
// Holds one entry, works out its own match flag, passes a prefix flag to the
// right and gathers the tail and pre-tail entries to the left.
// ============================================================================
module sdl_cell #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 32,
   parameter int IDX      = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sdl_pkg::sdl_ctrl_type             ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic signed [31:0]                key,
   input  logic signed [31:0]                new_value,
   input  logic [TAG_BITS-1:0]               new_tag,
   input  logic signed [31:0]                left_value,
   input  logic [TAG_BITS-1:0]               left_tag,
   input  logic signed [31:0]                right_value,
   input  logic [TAG_BITS-1:0]               right_tag,
   input  logic                              left_chain,
   output logic                              chain_out,
   input  logic signed [31:0]                right_tail_value,
   input  logic [TAG_BITS-1:0]               right_tail_tag,
   input  logic signed [31:0]                right_pre_value,
   input  logic [TAG_BITS-1:0]               right_pre_tag,
   output logic signed [31:0]                tail_value,
   output logic [TAG_BITS-1:0]               tail_tag,
   output logic signed [31:0]                pre_value,
   output logic [TAG_BITS-1:0]               pre_tag,
   output logic signed [31:0]                value,
   output logic [TAG_BITS-1:0]               tag
);
   import sdl_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW:0] I0 = (CW + 1)'(IDX);

   logic signed [31:0]  value_ff, value_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                hit_ff, blk_ff;
   logic signed [31:0]  tail_value_ff;
   logic [TAG_BITS-1:0] tail_tag_ff;
   logic signed [31:0]  pre_value_ff;
   logic [TAG_BITS-1:0] pre_tag_ff;

   logic [CW:0] nx;
   logic        middle, hit_now, is_tail, is_pre, at_pos, after_pos;

   assign nx      = {1'b0, count};
   assign middle  = (I0 != '0) && ((I0 + 1'b1) < nx);
   assign hit_now = middle && (ctrl.match_ge ? !(value_ff < key) : (value_ff == key));
   assign is_tail = (I0 + 1'b1) == nx;
   assign is_pre  = (I0 + 2'd2) == nx;

   always_comb begin
      case (ctrl.pos)
         POS_HEAD: begin
            at_pos    = (I0 == '0);
            after_pos = (I0 != '0);
         end
         POS_END: begin
            at_pos    = (I0 == nx);
            after_pos = 1'b0;
         end
         POS_LAST: begin
            at_pos    = is_tail;
            after_pos = (I0 >= nx);
         end
         default: begin
            at_pos    = hit_ff & ~blk_ff;
            after_pos = blk_ff;
         end
      endcase
   end

   always_comb begin
      value_in = value_ff;
      tag_in   = tag_ff;
      if (ctrl.apply_ins) begin
         if (at_pos) begin
            value_in = new_value;
            tag_in   = new_tag;
         end else if (after_pos) begin
            value_in = left_value;
            tag_in   = left_tag;
         end
      end else if (ctrl.apply_del && (at_pos || after_pos)) begin
         value_in = right_value;
         tag_in   = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tag_ff   <= tag_in;
      if (ctrl.scan) begin
         tail_value_ff <= is_tail ? value_ff : right_tail_value;
         tail_tag_ff   <= is_tail ? tag_ff   : right_tail_tag;
         pre_value_ff  <= is_pre  ? value_ff : right_pre_value;
         pre_tag_ff    <= is_pre  ? tag_ff   : right_pre_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         blk_ff <= 1'b0;
      end else if (ctrl.capture) begin
         hit_ff <= hit_now;
         blk_ff <= 1'b0;
      end else if (ctrl.scan) begin
         blk_ff <= left_chain;
      end
   end

   assign chain_out  = blk_ff | hit_ff;
   assign tail_value = tail_value_ff;
   assign tail_tag   = tail_tag_ff;
   assign pre_value  = pre_value_ff;
   assign pre_tag    = pre_tag_ff;
   assign value      = value_ff;
   assign tag        = tag_ff;

endmodule

// File: design/sdl_ctrl.sv
// ============================================================================
// sdl_ctrl: sequencer of the sorted deque list
// Accepts a request, runs the cell chains for a fixed scan, decides the
// operation from the gathered head and tail, and loads the response register.
// ============================================================================
module sdl_ctrl #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sdl_pkg::MODE_BITS-1:0]         req_mode,
   input  logic signed [31:0]                    req_key,
   input  logic [31:0]                           req_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sdl_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [sdl_pkg::COUNT_BITS-1:0]        rsp_count,
   output logic signed [31:0]                    rsp_head_value,
   output logic [31:0]                           rsp_head_tag,
   output logic signed [31:0]                    rsp_tail_value,
   output logic [31:0]                           rsp_tail_tag,
   output sdl_pkg::sdl_ctrl_type                 ctrl,
   output logic [$clog2(CAPACITY+1)-1:0]         count,
   output logic signed [31:0]                    new_value,
   output logic [TAG_BITS-1:0]                   new_tag,
   input  logic signed [31:0]                    head_value,
   input  logic [TAG_BITS-1:0]                   head_tag,
   input  logic signed [31:0]                    second_value,
   input  logic [TAG_BITS-1:0]                   second_tag,
   input  logic signed [31:0]                    tail_value,
   input  logic [TAG_BITS-1:0]                   tail_tag,
   input  logic signed [31:0]                    pre_value,
   input  logic [TAG_BITS-1:0]                   pre_tag,
   input  logic                                  any_hit
);
   import sdl_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] LAST_SCAN  = CW'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]           scan_ff, scan_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [MODE_BITS-1:0]    mode_ff;
   logic signed [31:0]      key_ff;
   logic [TAG_BITS-1:0]     tag_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_BITS-1:0]  status_ff;
   logic [COUNT_BITS-1:0]   rcount_ff;
   logic signed [31:0]      rhv_ff, rtv_ff;
   logic [31:0]             rht_ff, rtt_ff;

   logic                    accept, rsp_load;
   logic                    do_ins, do_del;
   sdl_pos_type             pos;
   logic [STATUS_BITS-1:0]  status;
   logic                    ge_head, ge_tail, eq_head, eq_tail, list_empty;
   logic signed [31:0]      nhv, ntv;
   logic [TAG_BITS-1:0]     nht, ntt;
   logic [63:0]             nht_ext, ntt_ext, tag_ext;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_SCAN) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign list_empty = (count_ff == '0);
   assign ge_head    = !(head_value < key_ff);
   assign ge_tail    = !(key_ff < tail_value);
   assign eq_head    = (head_value == key_ff);
   assign eq_tail    = (tail_value == key_ff);

   // Operation decision from the head, the gathered tail and the scan result.
   always_comb begin
      do_ins = 1'b0;
      do_del = 1'b0;
      pos    = POS_HEAD;
      status = ST_DONE;
      case (mode_ff) inside
         MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
            if (count_ff >= FULL_COUNT) begin
               status = ST_FULL;
            end else begin
               do_ins = 1'b1;
               if (mode_ff == MODE_PUSH_BACK) begin
                  pos = POS_END;
               end else if (mode_ff == MODE_INSERT && !list_empty) begin
                  if (ge_head) begin
                     pos = POS_HEAD;
                  end else if (ge_tail) begin
                     pos = POS_END;
                  end else if (any_hit) begin
                     pos = POS_FIRST;
                  end else begin
                     pos = POS_LAST;
                  end
               end
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end else if (mode_ff == MODE_POP_FRONT) begin
               do_del = 1'b1;
            end else if (mode_ff == MODE_POP_BACK) begin
               do_del = 1'b1;
               pos    = POS_LAST;
            end else if (eq_head) begin
               do_del = 1'b1;
            end else if (eq_tail) begin
               do_del = 1'b1;
               pos    = POS_LAST;
            end else if (any_hit) begin
               do_del = 1'b1;
               pos    = POS_FIRST;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   // Count, head and tail after the operation.
   always_comb begin
      count_in = count_ff;
      nhv      = head_value;
      nht      = head_tag;
      ntv      = tail_value;
      ntt      = tail_tag;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
         if (pos == POS_HEAD || list_empty) begin
            nhv = key_ff;
            nht = tag_ff;
         end
         if (pos == POS_END || list_empty) begin
            ntv = key_ff;
            ntt = tag_ff;
         end
      end else if (do_del) begin
         count_in = count_ff - 1'b1;
         if (pos == POS_HEAD) begin
            nhv = second_value;
            nht = second_tag;
         end
         if (pos == POS_LAST) begin
            ntv = pre_value;
            ntt = pre_tag;
         end
      end
   end

   assign nht_ext = 64'(nht);
   assign ntt_ext = 64'(ntt);
   assign tag_ext = 64'(req_tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (rsp_load) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         tag_ff  <= tag_ext[TAG_BITS-1:0];
      end
      if (rsp_load) begin
         status_ff <= status;
         rcount_ff <= COUNT_BITS'(count_in);
         if (count_in == '0) begin
            rhv_ff <= '0;
            rht_ff <= '0;
            rtv_ff <= '0;
            rtt_ff <= '0;
         end else begin
            rhv_ff <= nhv;
            rht_ff <= nht_ext[31:0];
            rtv_ff <= ntv;
            rtt_ff <= ntt_ext[31:0];
         end
      end
   end

   always_comb begin
      ctrl           = '0;
      ctrl.capture   = accept;
      ctrl.scan      = (state_ff == S_SCAN);
      ctrl.match_ge  = (req_mode == MODE_INSERT);
      ctrl.apply_ins = rsp_load && do_ins;
      ctrl.apply_del = rsp_load && do_del;
      ctrl.pos       = pos;
   end

   assign count          = count_ff;
   assign new_value      = key_ff;
   assign new_tag        = tag_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = rcount_ff;
   assign rsp_head_value = rhv_ff;
   assign rsp_head_tag   = rht_ff;
   assign rsp_tail_value = rtv_ff;
   assign rsp_tail_tag   = rtt_ff;

   // The list never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond capacity");

   // One request at a time: the port closes straight after an accept.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while one is in flight");

   // A rejected push is only reported for a full list.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status == ST_FULL) |-> (count_ff == FULL_COUNT))
      else $error("full status on a list with room");

   // Cells only change while a result is being loaded.
   a_apply_gated: assert property (@(posedge clock) disable iff (reset)
      (ctrl.apply_ins || ctrl.apply_del) |-> (state_ff == S_DECIDE))
      else $error("list changed outside the decision cycle");

endmodule

// File: design/sorted_deque_list_top.sv
// ============================================================================
// sorted_deque_list_top: bounded sorted deque of (value, tag) entries
// A chain of CAPACITY cells holds the list; a sequencer drives the chain.
// ============================================================================
// Usage. Each request on the req_ stream carries one operation in tuser
// (push front, push back, sorted insert, pop front, pop back, remove value)
// with a key value and a tag in tdata. Each request gives exactly one
// response on the rsp_ stream: a status in tuser, and the entry count with
// the head and tail entries after the operation in tdata (zeros when empty).
// Operation: a request is held for a scan along the cell chain, in which
// match flags ripple one cell to the right per cycle and the tail and
// pre-tail entries move one cell to the left per cycle; the decision state
// then decides the operation, shifts every cell at once and loads the
// response register, waiting while that register still holds an unread
// result. Only one request is in the block at a time: a new one is taken
// only once the previous one has loaded its response.
// Reset (synchronous, active high) empties the list; cell contents are left
// as they are and are never read beyond the entry count.
// When the receiver stalls the response register holds its request result;
// a new request may still be accepted and is held in the decision cycle
// until the register has been emptied.
// ============================================================================
module sorted_deque_list_top #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,    // key_value [31:0], tag [63:32]
   input  logic [7:0]    req_tuser,    // mode [2:0], zero [7:3]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,    // entry_count [4:0], head_value [36:5],
                                       // head_tag [68:37], tail_value [100:69],
                                       // tail_tag [132:101], zero [135:133]
   output logic [7:0]    rsp_tuser     // status [1:0], zero [7:2]
);
   import sdl_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   sdl_ctrl_type          ctrl;
   logic [CW-1:0]         count;
   logic signed [31:0]    new_value;
   logic [TAG_BITS-1:0]   new_tag;

   logic signed [31:0]    cell_value [CAPACITY];
   logic [TAG_BITS-1:0]   cell_tag   [CAPACITY];
   logic                  cell_chain [CAPACITY];
   logic signed [31:0]    cell_tv    [CAPACITY];
   logic [TAG_BITS-1:0]   cell_tt    [CAPACITY];
   logic signed [31:0]    cell_pv    [CAPACITY];
   logic [TAG_BITS-1:0]   cell_pt    [CAPACITY];

   logic [STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]  rsp_count;
   logic signed [31:0]     rsp_head_value, rsp_tail_value;
   logic [31:0]            rsp_head_tag, rsp_tail_tag;

   sdl_ctrl #(
      .CAPACITY (CAPACITY),
      .TAG_BITS (TAG_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser[MODE_BITS-1:0]),
      .req_key        (req_tdata[31:0]),
      .req_tag        (req_tdata[63:32]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_head_value (rsp_head_value),
      .rsp_head_tag   (rsp_head_tag),
      .rsp_tail_value (rsp_tail_value),
      .rsp_tail_tag   (rsp_tail_tag),
      .ctrl           (ctrl),
      .count          (count),
      .new_value      (new_value),
      .new_tag        (new_tag),
      .head_value     (cell_value[0]),
      .head_tag       (cell_tag[0]),
      .second_value   (cell_value[1]),
      .second_tag     (cell_tag[1]),
      .tail_value     (cell_tv[0]),
      .tail_tag       (cell_tt[0]),
      .pre_value      (cell_pv[0]),
      .pre_tag        (cell_pt[0]),
      .any_hit        (cell_chain[CAPACITY-1])
   );

   // The cell row: values shift in both directions, match flags ripple to
   // the right and the tail entries are gathered towards cell 0. The ends
   // of the row are tied off so that the first cell sees nothing on its
   // left and the last cell sees itself on its right.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0]  lv, rv, rtv, rpv;
      logic [TAG_BITS-1:0] lt, rt, rtt, rpt;
      logic                lc;

      if (i == 0) begin : g_first
         assign lv = '0;
         assign lt = '0;
         assign lc = 1'b0;
      end else begin : g_inner_left
         assign lv = cell_value[i-1];
         assign lt = cell_tag[i-1];
         assign lc = cell_chain[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rv  = cell_value[i];
         assign rt  = cell_tag[i];
         assign rtv = cell_value[i];
         assign rtt = cell_tag[i];
         assign rpv = cell_value[i];
         assign rpt = cell_tag[i];
      end else begin : g_inner_right
         assign rv  = cell_value[i+1];
         assign rt  = cell_tag[i+1];
         assign rtv = cell_tv[i+1];
         assign rtt = cell_tt[i+1];
         assign rpv = cell_pv[i+1];
         assign rpt = cell_pt[i+1];
      end

      sdl_cell #(
         .CAPACITY (CAPACITY),
         .TAG_BITS (TAG_BITS),
         .IDX      (i)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .ctrl             (ctrl),
         .count            (count),
         .key              (req_tdata[31:0]),
         .new_value        (new_value),
         .new_tag          (new_tag),
         .left_value       (lv),
         .left_tag         (lt),
         .right_value      (rv),
         .right_tag        (rt),
         .left_chain       (lc),
         .chain_out        (cell_chain[i]),
         .right_tail_value (rtv),
         .right_tail_tag   (rtt),
         .right_pre_value  (rpv),
         .right_pre_tag    (rpt),
         .tail_value       (cell_tv[i]),
         .tail_tag         (cell_tt[i]),
         .pre_value        (cell_pv[i]),
         .pre_tag          (cell_pt[i]),
         .value            (cell_value[i]),
         .tag              (cell_tag[i])
      );
   end

   assign rsp_tdata = {3'b000, rsp_tail_tag, rsp_tail_value,
                       rsp_head_tag, rsp_head_value, rsp_count};
   assign rsp_tuser = {6'b000000, rsp_status};

endmodule
